// File: hw/rtl/sps_pkg.sv
// Shared definitions for the static priority scheduler.
// Command and status codes, field widths and default sizes; no dependencies.
package sps_pkg;

    localparam int NUM_PRIORITIES_DEF = 32;
    localparam int TICK_WIDTH_DEF     = 16;

    localparam int CMD_W   = 2;
    localparam int PRIO_W  = 6;
    localparam int TICKS_W = 16;
    localparam int STAT_W  = 2;
    localparam int MASK_W  = 32;

    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELAY    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_IDLE_DELAY = 2'd1;
    localparam logic [STAT_W-1:0] ST_PRIO_TAKEN = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO_TICKS = 2'd3;

endpackage

// File: hw/rtl/sps_sleep_ram.sv
// Sleep-count store: one entry per priority, one write and one read port.
// Read data is registered. Uses sps_pkg for default sizes.
module sps_sleep_ram
    import sps_pkg::*;
#(
    parameter int DEPTH = NUM_PRIORITIES_DEF,
    parameter int WIDTH = TICK_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/static_priority_scheduler_top.sv
// Static priority scheduler: ready/delayed masks, per-priority sleep counts, current thread.
// From accepted request to result valid: register or rejected command go straight to S_DONE;
// schedule or delay scan in S_SCAN (downward bit scan, one priority a cycle); tick walks
// the sleep-count RAM in S_TICK one entry a cycle through its single read port; the result
// then waits in S_DONE while the output register stays full. One request at a time; the
// next is taken the cycle after the result enters the output register.
// Reset (rst_n, asynchronous, low): masks clear, only the idle thread registered and running.
module static_priority_scheduler_top
    import sps_pkg::*;
#(
    parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
    parameter int TICK_WIDTH     = TICK_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [PRIO_W-1:0]  thread_priority,
    input  logic [TICKS_W-1:0] delay_ticks,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PRIO_W-1:0]  next_thread,
    output logic               switch_request,
    output logic [STAT_W-1:0]  status,
    output logic [MASK_W-1:0]  ready_mask,
    output logic [MASK_W-1:0]  delayed_mask
);

    localparam int PIDX_W = $clog2(NUM_PRIORITIES);
    localparam int RIDX_W = $clog2(NUM_PRIORITIES + 1);
    localparam int CNT_W  = $clog2(NUM_PRIORITIES + 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(NUM_PRIORITIES);
    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
    localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(NUM_PRIORITIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TICK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                state_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      pend_reg;
    logic [PIDX_W-1:0]         pend_idx_reg;
    logic [NUM_PRIORITIES-1:0] ready_reg;
    logic [NUM_PRIORITIES-1:0] delayed_reg;
    logic [NUM_PRIORITIES:0]   registered_reg;
    logic [PRIO_W-1:0]         running_reg;
    logic [PRIO_W-1:0]         res_thread_reg;
    logic                      res_sw_reg;
    logic [STAT_W-1:0]         res_status_reg;

    logic                      out_valid_reg;
    logic [PRIO_W-1:0]         next_thread_reg;
    logic                      switch_reg;
    logic [STAT_W-1:0]         status_reg;
    logic [MASK_W-1:0]         ready_mask_reg;
    logic [MASK_W-1:0]         delayed_mask_reg;

    logic                      accept;
    logic [TICK_WIDTH-1:0]     ticks_in;
    logic [PRIO_W-1:0]         run_m1;
    logic [PRIO_W-1:0]         prio_m1;
    logic                      delay_ok;
    logic                      reg_ok;
    logic                      tick_hit;
    logic [TICK_WIDTH-1:0]     tick_dec;
    logic                      rd_en;
    logic [TICK_WIDTH-1:0]     rd_data;
    logic                      wr_en;
    logic [PIDX_W-1:0]         wr_addr;
    logic [TICK_WIDTH-1:0]     wr_data;
    logic [CNT_W-1:0]          cnt_m1;
    logic                      scan_hit;
    logic                      scan_done;
    logic [PRIO_W-1:0]         scan_sel;
    logic                      out_free;

    always_comb
    begin
        accept    = in_valid && in_ready;
        ticks_in  = TICK_WIDTH'(delay_ticks);
        run_m1    = running_reg - 1'b1;
        prio_m1   = thread_priority - 1'b1;
        delay_ok  = (running_reg != '0) && (ticks_in != '0);
        reg_ok    = (thread_priority <= PRIO_MAX)
                    && !registered_reg[thread_priority[RIDX_W-1:0]];
        tick_hit  = (state_reg == S_TICK) && pend_reg && delayed_reg[pend_idx_reg];
        tick_dec  = rd_data - 1'b1;
        rd_en     = (state_reg == S_TICK) && (cnt_reg < CNT_MAX);
        wr_en     = (accept && (command == CMD_DELAY) && delay_ok) || tick_hit;
        wr_addr   = tick_hit ? pend_idx_reg : run_m1[PIDX_W-1:0];
        wr_data   = tick_hit ? tick_dec : ticks_in;
        cnt_m1    = cnt_reg - 1'b1;
        scan_hit  = ready_reg[cnt_m1[PIDX_W-1:0]];
        scan_done = scan_hit || (cnt_reg == CNT_ONE);
        scan_sel  = scan_hit ? PRIO_W'(cnt_reg) : '0;
        out_free  = !out_valid_reg || out_ready;
    end

    sps_sleep_ram #(
        .DEPTH (NUM_PRIORITIES),
        .WIDTH (TICK_WIDTH)
    ) u_sleep_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[PIDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            ready_reg      <= '0;
            delayed_reg    <= '0;
            registered_reg <= (NUM_PRIORITIES + 1)'(1);
            running_reg    <= '0;
            res_thread_reg <= '0;
            res_sw_reg     <= 1'b0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_thread_reg <= running_reg;
                        res_sw_reg     <= 1'b0;
                        case (command)
                            CMD_TICK:
                            begin
                                res_status_reg <= ST_OK;
                                cnt_reg        <= '0;
                                pend_reg       <= 1'b0;
                                state_reg      <= S_TICK;
                            end
                            CMD_DELAY:
                            begin
                                if (running_reg == '0)
                                begin
                                    res_status_reg <= ST_IDLE_DELAY;
                                    state_reg      <= S_DONE;
                                end
                                else if (ticks_in == '0)
                                begin
                                    res_status_reg <= ST_ZERO_TICKS;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    ready_reg[run_m1[PIDX_W-1:0]]   <= 1'b0;
                                    delayed_reg[run_m1[PIDX_W-1:0]] <= 1'b1;
                                    res_status_reg <= ST_OK;
                                    cnt_reg        <= CNT_MAX;
                                    state_reg      <= S_SCAN;
                                end
                            end
                            CMD_REGISTER:
                            begin
                                state_reg <= S_DONE;
                                if (reg_ok)
                                begin
                                    res_status_reg <= ST_OK;
                                    registered_reg[thread_priority[RIDX_W-1:0]] <= 1'b1;
                                    if (thread_priority != '0)
                                    begin
                                        ready_reg[prio_m1[PIDX_W-1:0]] <= 1'b1;
                                    end
                                end
                                else
                                begin
                                    res_status_reg <= ST_PRIO_TAKEN;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= ST_OK;
                                cnt_reg        <= CNT_MAX;
                                state_reg      <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_TICK:
                begin
                    // read entry cnt while the previous entry is written back
                    if (rd_en)
                    begin
                        cnt_reg      <= cnt_reg + 1'b1;
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= cnt_reg[PIDX_W-1:0];
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (tick_hit && (tick_dec == '0))
                    begin
                        ready_reg[pend_idx_reg]   <= 1'b1;
                        delayed_reg[pend_idx_reg] <= 1'b0;
                    end
                    if (!rd_en && !pend_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        res_thread_reg <= scan_sel;
                        res_sw_reg     <= (scan_sel != running_reg);
                        running_reg    <= scan_sel;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_m1;
                    end
                end
                default:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            next_thread_reg  <= res_thread_reg;
            switch_reg       <= res_sw_reg;
            status_reg       <= res_status_reg;
            ready_mask_reg   <= MASK_W'(ready_reg);
            delayed_mask_reg <= MASK_W'(delayed_reg);
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign next_thread    = next_thread_reg;
    assign switch_request = switch_reg;
    assign status         = status_reg;
    assign ready_mask     = ready_mask_reg;
    assign delayed_mask   = delayed_mask_reg;

    // a thread is never ready and delayed at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg & delayed_reg) == '0)
        else $error("thread both ready and delayed");

    // the running thread is always a registered priority
    assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg <= PRIO_MAX) && registered_reg[running_reg[RIDX_W-1:0]])
        else $error("running thread not registered");

    // sleep counts are written only on a delay request or during a tick walk
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_IDLE) || (state_reg == S_TICK)))
        else $error("sleep count written outside delay or tick");

    // a tick walk finishes with its pipeline drained
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_TICK) && !rd_en && !pend_reg) |=> (state_reg == S_DONE))
        else $error("tick walk did not finish");

endmodule
